### rtl/secure_link_frame_delimiter_defines.svh
// ---------------------------------------------------------------------------
// secure_link_frame_delimiter_defines
// assertion macros used by the frame delimiter core
// ---------------------------------------------------------------------------
`ifndef SECURE_LINK_FRAME_DELIMITER_DEFINES_SVH
`define SECURE_LINK_FRAME_DELIMITER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SFD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfd assertion failed");
`define SFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfd assertion failed");
`else
`define SFD_ASSERT_SAME(label, ante, cons)
`define SFD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/sfd_pkg.sv
// ---------------------------------------------------------------------------
// sfd_pkg
// types and constants of the secure link frame delimiter
// ---------------------------------------------------------------------------
package sfd_pkg;

    localparam logic [7:0] START_V1 = 8'd254;
    localparam logic [7:0] START_V2 = 8'd253;

    localparam logic [3:0] HDR_V1  = 4'd6;
    localparam logic [3:0] HDR_V2  = 4'd10;
    localparam logic [1:0] CRC_LEN = 2'd2;
    localparam int         BLOCK   = 16;

    localparam logic [8:0] PAD_ADD  = 9'(BLOCK - 1);
    localparam logic [8:0] PAD_MASK = ~PAD_ADD;

    localparam logic [8:0] POS_LENGTH    = 9'd1;
    localparam logic [8:0] POS_COMPONENT = 9'd6;
    localparam logic [8:0] POS_LIMIT     = 9'd336;

    localparam int         PADDR_W = 4;
    localparam logic [1:0] REG_SECURE_MODE = 2'd0;
    localparam logic [1:0] REG_RADIO_ID    = 2'd1;
    localparam logic [1:0] REG_TAG_BYTES   = 2'd2;

    localparam logic       RST_SECURE_MODE = 1'b0;
    localparam logic [7:0] RST_RADIO_ID    = 8'd68;
    localparam logic [5:0] RST_TAG_BYTES   = 6'd13;

    typedef enum logic [1:0] {
        KIND_V1     = 2'd0,
        KIND_RADIO  = 2'd1,
        KIND_SECURE = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ROLE_HEADER   = 2'd0,
        ROLE_BODY     = 2'd1,
        ROLE_CHECKSUM = 2'd2,
        ROLE_TAG      = 2'd3
    } role_t;

    typedef struct packed {
        logic       secure_mode;
        logic [7:0] radio_component_id;
        logic [5:0] tag_bytes;
    } cfg_t;

    typedef struct packed {
        logic [7:0] out_byte;
        kind_t      frame_kind;
        role_t      byte_role;
        logic       first_of_frame;
        logic       last_of_frame;
    } result_t;

endpackage

### rtl/sfd_link_if.sv
// ---------------------------------------------------------------------------
// sfd_link_if
// byte channel into the frame delimiter
// ---------------------------------------------------------------------------
interface sfd_link_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

### rtl/sfd_frame_if.sv
// ---------------------------------------------------------------------------
// sfd_frame_if
// tagged frame byte channel out of the frame delimiter
// ---------------------------------------------------------------------------
interface sfd_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] frame_kind;
    logic [1:0] byte_role;
    logic       first_of_frame;
    logic       last_of_frame;

    modport source (
        output valid, output out_byte, output frame_kind, output byte_role,
        output first_of_frame, output last_of_frame, input ready
    );
    modport sink (
        input valid, input out_byte, input frame_kind, input byte_role,
        input first_of_frame, input last_of_frame, output ready
    );
endinterface

### rtl/sfd_cfg.sv
// ---------------------------------------------------------------------------
// sfd_cfg
// apb register file: secure mode, radio component id, tag byte count
// ---------------------------------------------------------------------------
module sfd_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sfd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output sfd_pkg::cfg_t               cfg
);
    import sfd_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] index;
    logic       wr_en;

    assign pready = 1'b1;
    assign index  = paddr[3:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (index)
                REG_SECURE_MODE: cfg_next.secure_mode        = pwdata[0];
                REG_RADIO_ID:    cfg_next.radio_component_id = pwdata[7:0];
                REG_TAG_BYTES:   cfg_next.tag_bytes          = pwdata[5:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_SECURE_MODE: prdata = {31'd0, cfg_reg.secure_mode};
            REG_RADIO_ID:    prdata = {24'd0, cfg_reg.radio_component_id};
            REG_TAG_BYTES:   prdata = {26'd0, cfg_reg.tag_bytes};
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.secure_mode        <= RST_SECURE_MODE;
            cfg_reg.radio_component_id <= RST_RADIO_ID;
            cfg_reg.tag_bytes          <= RST_TAG_BYTES;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### rtl/sfd_core.sv
// ---------------------------------------------------------------------------
// sfd_core
// frame tracking state and per-byte role, kind and end decision
// ---------------------------------------------------------------------------
`include "secure_link_frame_delimiter_defines.svh"

module sfd_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  logic [7:0]       in_byte,
    input  sfd_pkg::cfg_t    cfg,
    output logic             emit,
    output sfd_pkg::result_t result
);
    import sfd_pkg::*;

    logic       in_frame_reg, in_frame_next;
    logic [8:0] pos_reg, pos_next;
    logic [7:0] plen_reg, plen_next;
    kind_t      kind_reg, kind_next;
    logic [8:0] body_reg, body_next;

    logic       is_start;
    logic [8:0] pos;
    logic [7:0] plen;
    kind_t      kind;
    logic [8:0] body;
    logic [8:0] padded;
    logic [3:0] hdr;
    logic [9:0] pos_w;
    logic [9:0] hdr_end;
    logic [9:0] body_end;
    logic [9:0] crc_end;
    logic [9:0] frame_end;
    logic       end_known;
    logic       last;
    role_t      role;

    always_comb
    begin
        is_start = (in_byte == START_V1) || (in_byte == START_V2);
        emit     = take && (in_frame_reg || is_start);

        pos  = in_frame_reg ? pos_reg : 9'd0;
        plen = in_frame_reg ? plen_reg : 8'd0;
        body = in_frame_reg ? body_reg : 9'd0;
        if (in_frame_reg)
            kind = kind_reg;
        else if (in_byte == START_V1)
            kind = KIND_V1;
        else
            kind = KIND_SECURE;

        if (pos == POS_LENGTH)
        begin
            plen = in_byte;
            body = {1'b0, in_byte};
        end

        padded = ({1'b0, plen} + PAD_ADD) & PAD_MASK;
        if ((kind != KIND_V1) && (pos == POS_COMPONENT))
        begin
            if (in_byte == cfg.radio_component_id)
            begin
                kind = KIND_RADIO;
                body = {1'b0, plen};
            end
            else
            begin
                kind = KIND_SECURE;
                body = cfg.secure_mode ? {1'b0, plen} : padded;
            end
        end

        hdr      = (kind == KIND_V1) ? HDR_V1 : HDR_V2;
        pos_w    = {1'b0, pos};
        hdr_end  = 10'(hdr);
        body_end = hdr_end + {1'b0, body};
        crc_end  = body_end + 10'(CRC_LEN);
        if ((kind == KIND_SECURE) && cfg.secure_mode)
            frame_end = crc_end + 10'(cfg.tag_bytes);
        else
            frame_end = crc_end;

        if (pos_w < hdr_end)
            role = ROLE_HEADER;
        else if (pos_w < body_end)
            role = ROLE_BODY;
        else if (pos_w < crc_end)
            role = ROLE_CHECKSUM;
        else
            role = ROLE_TAG;

        end_known = (kind == KIND_V1) ? (pos >= POS_LENGTH) : (pos >= POS_COMPONENT);
        last      = end_known && ((pos_w + 10'd1) >= frame_end);

        result.out_byte       = in_byte;
        result.frame_kind     = kind;
        result.byte_role      = role;
        result.first_of_frame = !in_frame_reg;
        result.last_of_frame  = last;

        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        plen_next     = plen_reg;
        kind_next     = kind_reg;
        body_next     = body_reg;
        if (emit)
        begin
            in_frame_next = !last;
            pos_next      = last ? 9'd0 : (pos + 9'd1);
            plen_next     = plen;
            kind_next     = kind;
            body_next     = body;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            pos_reg      <= 9'd0;
            plen_reg     <= 8'd0;
            kind_reg     <= KIND_V1;
            body_reg     <= 9'd0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            pos_reg      <= pos_next;
            plen_reg     <= plen_next;
            kind_reg     <= kind_next;
            body_reg     <= body_next;
        end
    end

    `SFD_ASSERT_NEXT(a_last_ends_frame, emit && last, !in_frame_reg)
    `SFD_ASSERT_SAME(a_first_is_start, emit && !in_frame_reg, is_start)
    `SFD_ASSERT_NEXT(a_noise_dropped, take && !in_frame_reg && !is_start, !in_frame_reg)
    `SFD_ASSERT_SAME(a_pos_bounded, in_frame_reg, pos_reg < POS_LIMIT)
    `SFD_ASSERT_SAME(a_v1_no_tag, emit && (kind == KIND_V1), role != ROLE_TAG)

endmodule

### rtl/secure_link_frame_delimiter.sv
// ---------------------------------------------------------------------------
// secure_link_frame_delimiter
// finds v1, radio v2 and secured v2 frames in a link byte stream and tags
// every frame byte with its kind, role and first/last marks
// a frame byte is registered and appears on the output in the cycle after its beat
// throughput: one byte per cycle while frame.ready is high, set by the single result register
// bytes outside a frame while hunting give no output beat
// reset: rst_n async active low, hunting for a start byte, registers at
// secure_mode 0, radio_component_id 68, tag_bytes 13
// ---------------------------------------------------------------------------
module secure_link_frame_delimiter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sfd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    sfd_link_if.sink                    link,
    sfd_frame_if.source                 frame
);
    import sfd_pkg::*;

    cfg_t    cfg;
    logic    take;
    logic    emit;
    result_t result;

    logic    out_valid_reg, out_valid_next;
    result_t result_reg;

    sfd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sfd_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .in_byte (link.in_byte),
        .cfg     (cfg),
        .emit    (emit),
        .result  (result)
    );

    assign link.ready = !out_valid_reg || frame.ready;
    assign take       = link.valid && link.ready;

    always_comb
    begin
        if (emit)
            out_valid_next = 1'b1;
        else if (frame.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            result_reg <= result;
    end

    assign frame.valid          = out_valid_reg;
    assign frame.out_byte       = result_reg.out_byte;
    assign frame.frame_kind     = result_reg.frame_kind;
    assign frame.byte_role      = result_reg.byte_role;
    assign frame.first_of_frame = result_reg.first_of_frame;
    assign frame.last_of_frame  = result_reg.last_of_frame;

endmodule
